// ===== sv/coracc_pkg.sv =====
// Shared constants for the Coriolis acceleration pipeline: CORDIC gain seed,
// arctangent table in binary-angle units and fixed-point widths.
// No dependencies.
package coracc_pkg;

  // Number of entries in the arctangent table; the CORDIC never runs more stages
  localparam int CORDIC_TAB_LEN = 32;

  // CORDIC datapath width: Q.30 x/y and binary angle z with growth headroom
  localparam int ANG_W = 34;

  // Velocity, acceleration and sin/cos word width
  localparam int WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [ANG_W-1:0]  ang_t;

  // Quarter turn in units of pi*2^-31, also 1.0 in Q.30
  localparam ang_t QUARTER_TURN = ang_t'(64'sd1073741824);
  localparam ang_t HALF_TURN    = ang_t'(64'sd2147483648);

  // round(K * 2^30), CORDIC gain for many stages
  localparam ang_t CORDIC_X0 = ang_t'(64'sd652032874);

  // Reset value of the rotation rate, units of 2^-40 rad/s
  localparam logic [31:0] ROT_RATE_RESET = 32'd80177000;

  // atan(2^-i) in units of pi*2^-31
  localparam logic [31:0] ATAN_TAB [CORDIC_TAB_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

endpackage

// ===== sv/coriolis_acceleration.sv =====
// Coriolis acceleration of one grid cell: pipelined CORDIC sin/cos followed by
// velocity products, rate scaling with rounding and saturation.
// Depends on coracc_pkg.
//
// Usage
//   Input channel: drive in_vel_lat/lon/alt (signed Q16.16) and in_latitude
//   (binary angle, pi*2^-31 rad) with start high. A transaction is taken at
//   every rising edge with start high and busy low; busy is always low, so
//   one cell enters per clock with no gaps required.
//   Result channel: out_valid is high for exactly one cycle with the three
//   accelerations (signed Q16.16, saturated). The receiver cannot stall.
//   A cell passes the folded input stage, the CORDIC rotation stages
//   (CORDIC_STAGES capped at 32), then the clamp, product, magnitude,
//   partial-product, rounding and output registers. Throughput: one cell
//   per cycle, with one rotation and multiplies of at most 32x32 per stage.
//   Configuration: cfg_we with cfg_wdata writes the rotation rate W
//   (unsigned, 2^-40 rad/s); write only while no transaction is in flight.
//   Reset (synchronous, rst_n low): all valid bits clear, so no result
//   emerges from work in flight, and W returns to 80177000.
module coriolis_acceleration
  import coracc_pkg::*;
#(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_vel_lat,
  input  logic signed [31:0] in_vel_lon,
  input  logic signed [31:0] in_vel_alt,
  input  logic signed [31:0] in_latitude,
  // result channel
  output logic               out_valid,
  output logic signed [31:0] out_accel_lat,
  output logic signed [31:0] out_accel_lon,
  output logic signed [31:0] out_accel_alt,
  // configuration
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);

  localparam int NSTG = (CORDIC_STAGES < CORDIC_TAB_LEN) ? CORDIC_STAGES : CORDIC_TAB_LEN;
  localparam int NLANE = 3;
  localparam logic [95:0] ROUND_HALF = 96'h1 << 68;

  // Rotation rate register
  logic [31:0] rot_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_rate_r <= ROT_RATE_RESET;
    end else if (cfg_we) begin
      rot_rate_r <= cfg_wdata;
    end
  end

  // The pipeline never stalls
  assign busy = 1'b0;

  // CORDIC pipeline registers; index 0 is the folded input stage
  logic  vld_r  [NSTG+1];
  ang_t  cx_r   [NSTG+1];
  ang_t  cy_r   [NSTG+1];
  ang_t  cz_r   [NSTG+1];
  logic  flip_r [NSTG+1];
  word_t vlat_r [NSTG+1];
  word_t vlon_r [NSTG+1];
  word_t valt_r [NSTG+1];

  // Fold latitude into [-pi/2, pi/2], remembering to negate cos
  ang_t lat_ext;
  ang_t z0_nxt;
  logic flip0_nxt;

  always_comb begin
    lat_ext   = ang_t'(in_latitude);
    z0_nxt    = lat_ext;
    flip0_nxt = 1'b0;
    if (lat_ext > QUARTER_TURN) begin
      z0_nxt    = HALF_TURN - lat_ext;
      flip0_nxt = 1'b1;
    end else if (lat_ext < -QUARTER_TURN) begin
      z0_nxt    = -HALF_TURN - lat_ext;
      flip0_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= start & ~busy;
    end
    cx_r[0]   <= CORDIC_X0;
    cy_r[0]   <= '0;
    cz_r[0]   <= z0_nxt;
    flip_r[0] <= flip0_nxt;
    vlat_r[0] <= in_vel_lat;
    vlon_r[0] <= in_vel_lon;
    valt_r[0] <= in_vel_alt;
  end

  // One rotation per stage
  for (genvar i = 0; i < NSTG; i++) begin : g_cordic
    ang_t dx;
    ang_t dy;
    ang_t at;

    assign dx = cy_r[i] >>> i;
    assign dy = cx_r[i] >>> i;
    assign at = $signed({{(ANG_W-32){1'b0}}, ATAN_TAB[i]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      if (!cz_r[i][ANG_W-1]) begin
        cx_r[i+1] <= cx_r[i] - dx;
        cy_r[i+1] <= cy_r[i] + dy;
        cz_r[i+1] <= cz_r[i] - at;
      end else begin
        cx_r[i+1] <= cx_r[i] + dx;
        cy_r[i+1] <= cy_r[i] - dy;
        cz_r[i+1] <= cz_r[i] + at;
      end
      flip_r[i+1] <= flip_r[i];
      vlat_r[i+1] <= vlat_r[i];
      vlon_r[i+1] <= vlon_r[i];
      valt_r[i+1] <= valt_r[i];
    end
  end

  // Apply fold sign and clamp sin/cos to [-1, 1] in Q.30
  ang_t  cos_pre;
  ang_t  sin_cl;
  ang_t  cos_cl;
  logic  clamp_vld_r;
  word_t sin_r;
  word_t cos_r;
  word_t clamp_vlat_r;
  word_t clamp_vlon_r;
  word_t clamp_valt_r;

  always_comb begin
    cos_pre = flip_r[NSTG] ? -cx_r[NSTG] : cx_r[NSTG];
    sin_cl  = cy_r[NSTG];
    if (sin_cl > QUARTER_TURN) begin
      sin_cl = QUARTER_TURN;
    end else if (sin_cl < -QUARTER_TURN) begin
      sin_cl = -QUARTER_TURN;
    end
    cos_cl = cos_pre;
    if (cos_cl > QUARTER_TURN) begin
      cos_cl = QUARTER_TURN;
    end else if (cos_cl < -QUARTER_TURN) begin
      cos_cl = -QUARTER_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_vld_r <= 1'b0;
    end else begin
      clamp_vld_r <= vld_r[NSTG];
    end
    sin_r        <= word_t'(sin_cl);
    cos_r        <= word_t'(cos_cl);
    clamp_vlat_r <= vlat_r[NSTG];
    clamp_vlon_r <= vlon_r[NSTG];
    clamp_valt_r <= valt_r[NSTG];
  end

  // Exact velocity products, units 2^-46
  logic               prod_vld_r;
  logic signed [63:0] lon_s_r;
  logic signed [63:0] lat_s_r;
  logic signed [63:0] alt_c_r;
  logic signed [63:0] lon_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= clamp_vld_r;
    end
    lon_s_r <= clamp_vlon_r * sin_r;
    lat_s_r <= clamp_vlat_r * sin_r;
    alt_c_r <= clamp_valt_r * cos_r;
    lon_c_r <= clamp_vlon_r * cos_r;
  end

  // Form each lane's sum, then split into sign and magnitude
  logic signed [63:0] sum_nxt [NLANE];
  logic               mag_vld_r;
  logic               neg_r   [NLANE];
  logic [62:0]        abs_r   [NLANE];

  assign sum_nxt[0] = -lon_s_r;
  assign sum_nxt[1] = lat_s_r - alt_c_r;
  assign sum_nxt[2] = lon_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_vld_r <= 1'b0;
    end else begin
      mag_vld_r <= prod_vld_r;
    end
  end

  // Partial products, rounding and saturation per lane
  logic        part_vld_r;
  logic        rnd_vld_r;
  logic        out_vld_r;
  word_t       res_r [NLANE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_vld_r <= 1'b0;
      rnd_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      part_vld_r <= mag_vld_r;
      rnd_vld_r  <= part_vld_r;
      out_vld_r  <= rnd_vld_r;
    end
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    logic [63:0] abs_nxt;
    logic [63:0] lo_r;
    logic [62:0] hi_r;
    logic        part_neg_r;
    logic [95:0] total;
    logic [26:0] mag_r;
    logic        rnd_neg_r;
    logic [32:0] magx;
    logic [32:0] magx_neg;
    word_t       res_nxt;

    assign abs_nxt = sum_nxt[l][63] ? 64'(-sum_nxt[l]) : 64'(sum_nxt[l]);

    // Round (2*W*p) / 2^70 half away from zero on the magnitude
    assign total = {1'b0, hi_r, 32'd0} + {32'd0, lo_r} + ROUND_HALF;

    // Saturate to the signed 32-bit range
    always_comb begin
      magx     = {6'd0, mag_r};
      magx_neg = -magx;
      if (rnd_neg_r) begin
        res_nxt = (magx > 33'h080000000) ? word_t'(32'h80000000) : word_t'(magx_neg[31:0]);
      end else begin
        res_nxt = (magx > 33'h07FFFFFFF) ? word_t'(32'h7FFFFFFF) : word_t'(magx[31:0]);
      end
    end

    always_ff @(posedge clk) begin
      neg_r[l]   <= sum_nxt[l][63];
      abs_r[l]   <= abs_nxt[62:0];
      lo_r       <= {32'd0, abs_r[l][31:0]} * {32'd0, rot_rate_r};
      hi_r       <= 63'({33'd0, abs_r[l][62:32]} * {32'd0, rot_rate_r});
      part_neg_r <= neg_r[l];
      mag_r      <= total[95:69];
      rnd_neg_r  <= part_neg_r;
      res_r[l]   <= res_nxt;
    end
  end

  // Drive the result ports
  assign out_valid     = out_vld_r;
  assign out_accel_lat = res_r[0];
  assign out_accel_lon = res_r[1];
  assign out_accel_alt = res_r[2];

endmodule

// ===== sv/coracc_checker.sv =====
// Port-level checks for the Coriolis acceleration block, bound to its top level.
// Depends on coracc_pkg and coriolis_acceleration.
module coracc_checker
  import coracc_pkg::*;
#(
  parameter int CORDIC_STAGES = 24
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] in_vel_lat,
  input logic signed [31:0] in_vel_lon,
  input logic signed [31:0] in_vel_alt,
  input logic               out_valid,
  input logic signed [31:0] out_accel_lat,
  input logic signed [31:0] out_accel_lon,
  input logic signed [31:0] out_accel_alt
);

  localparam int NSTG = (CORDIC_STAGES < CORDIC_TAB_LEN) ? CORDIC_STAGES : CORDIC_TAB_LEN;
  localparam int LAT  = NSTG + 7;

  // Every accepted transaction yields exactly one result, a fixed latency later
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching transaction");

  // Zero velocity gives zero acceleration
  a_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_vel_lat == 0 && in_vel_lon == 0 && in_vel_alt == 0)
      |-> ##LAT (out_accel_lat == 0 && out_accel_lon == 0 && out_accel_alt == 0))
    else $error("nonzero acceleration for zero velocity");

  // With no longitudinal velocity the lat and alt terms vanish
  a_zero_lon: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_vel_lon == 0)
      |-> ##LAT (out_accel_lat == 0 && out_accel_alt == 0))
    else $error("lat/alt acceleration without longitudinal velocity");

endmodule

bind coriolis_acceleration coracc_checker #(
  .CORDIC_STAGES(CORDIC_STAGES)
) u_coracc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_vel_lat    (in_vel_lat),
  .in_vel_lon    (in_vel_lon),
  .in_vel_alt    (in_vel_alt),
  .out_valid     (out_valid),
  .out_accel_lat (out_accel_lat),
  .out_accel_lon (out_accel_lon),
  .out_accel_alt (out_accel_alt)
);
